// ===== sv/tdb_pkg.sv =====
// Shared constants, command codes and types for the text display buffer unit.
package tdb_pkg;

	localparam int CELLS = 160;
	localparam int POS_W = 8;
	localparam int IDX_W = $clog2(CELLS);
	localparam int CMD_W = 4;
	localparam int CHR_W = 8;

	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(CELLS - 1);
	localparam logic [POS_W-1:0] CELLS_POS = POS_W'(CELLS);

	typedef enum logic [CMD_W-1:0] {
		CMD_STOP       = 4'd0,
		CMD_SET_POS    = 4'd1,
		CMD_WRITE      = 4'd2,
		CMD_WRITE_NEXT = 4'd3,
		CMD_NEXT       = 4'd4,
		CMD_PREV       = 4'd5,
		CMD_OUT_ADDR   = 4'd6,
		CMD_OUT_CHAR   = 4'd7,
		CMD_HOME       = 4'd8,
		CMD_CLEAR      = 4'd9
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_ADDR = 2'd1,
		MODE_CHAR = 2'd2
	} mode_t;

	// Request from the command logic to the character store.
	typedef struct packed {
		logic             wr_en;
		logic             clr;
		logic             rd_en;
		logic [IDX_W-1:0] wr_addr;
		logic [IDX_W-1:0] rd_addr;
		logic [CHR_W-1:0] wr_data;
	} store_req_t;

endpackage

// ===== sv/tdb_if.sv =====
// Valid/ready channel interfaces for commands in and bus results out.
interface tdb_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [tdb_pkg::CMD_W-1:0] action;
	logic [tdb_pkg::CHR_W-1:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface tdb_bus_if;
	logic                      valid;
	logic                      ready;
	logic                      bus_driven;
	logic [tdb_pkg::CHR_W-1:0] bus_value;

	modport source (output valid, output bus_driven, output bus_value, input ready);
	modport sink   (input valid, input bus_driven, input bus_value, output ready);
endinterface

// ===== sv/tdb_store.sv =====
// Character store: synchronous RAM with per-cell valid bits and write forwarding.
module tdb_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tdb_pkg::store_req_t       req,
	output logic [tdb_pkg::CHR_W-1:0] rd_data
);
	import tdb_pkg::*;

	logic [CHR_W-1:0] mem [CELLS];
	logic [CELLS-1:0] valid_q;
	logic [CHR_W-1:0] mem_rd_s1;
	logic [CHR_W-1:0] fwd_data_s1;
	logic             fwd_s1;
	logic             hit_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_rd_s1   <= mem[req.rd_addr];
			fwd_data_s1 <= req.wr_data;
		end
	end

	// Cells never written since reset or clear read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fwd_s1  <= 1'b0;
			hit_s1  <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				// read-old RAM: a write to the same cell this beat is forwarded
				fwd_s1 <= req.wr_en && (req.wr_addr == req.rd_addr);
				hit_s1 <= !req.clr && valid_q[req.rd_addr];
			end
		end
	end

	always_comb begin
		if (fwd_s1) begin
			rd_data = fwd_data_s1;
		end else if (hit_s1) begin
			rd_data = mem_rd_s1;
		end else begin
			rd_data = '0;
		end
	end

endmodule

// ===== sv/text_display_buffer_unit.sv =====
// Text display buffer unit: command decode, cursor and mode, result register.
// Latency: a result is offered in the cycle after its command beat is accepted.
// Throughput: one command per cycle while the bus takes results; the store reads at the new
// cursor in the accept cycle and its registered read data drives the result directly.
// Reset (arst_n low): cursor and mode to zero, all cell valid bits cleared, so
// the store reads as all zero at once; clear zeroes cursor and valid bits, not mode.
module text_display_buffer_unit (
	input  logic          clk,
	input  logic          arst_n,
	tdb_cmd_if.sink       cmd_ch,
	tdb_bus_if.source     bus_ch
);
	import tdb_pkg::*;

	logic [POS_W-1:0] cursor_q;
	mode_t            mode_q;
	logic             valid_s1;
	logic [POS_W-1:0] cursor_s1;
	mode_t            mode_s1;

	cmd_t             cmd;
	logic             accept;
	logic [POS_W-1:0] cursor_nxt;
	mode_t            mode_nxt;
	logic             wr_cmd;
	store_req_t       req;
	logic [CHR_W-1:0] rd_char;

	assign cmd    = cmd_t'(cmd_ch.action);
	assign cmd_ch.ready = !valid_s1 || bus_ch.ready;
	assign accept = cmd_ch.valid && cmd_ch.ready;

	always_comb begin
		cursor_nxt = cursor_q;
		mode_nxt   = mode_q;
		wr_cmd     = 1'b0;
		case (cmd)
			CMD_STOP:       mode_nxt = MODE_NONE;
			CMD_SET_POS:    cursor_nxt = (cmd_ch.data_byte >= CELLS_POS) ? '0 : cmd_ch.data_byte;
			CMD_WRITE:      wr_cmd = 1'b1;
			CMD_WRITE_NEXT: begin
				wr_cmd     = 1'b1;
				cursor_nxt = (cursor_q >= LAST_POS) ? '0 : cursor_q + 1'b1;
			end
			CMD_NEXT:       cursor_nxt = (cursor_q >= LAST_POS) ? '0 : cursor_q + 1'b1;
			CMD_PREV:       cursor_nxt = (cursor_q == '0) ? LAST_POS : cursor_q - 1'b1;
			CMD_OUT_ADDR:   mode_nxt = MODE_ADDR;
			CMD_OUT_CHAR:   mode_nxt = MODE_CHAR;
			CMD_HOME:       cursor_nxt = '0;
			CMD_CLEAR:      cursor_nxt = '0;
			default:        ;
		endcase
	end

	always_comb begin
		req.wr_en   = accept && wr_cmd;
		req.clr     = accept && (cmd == CMD_CLEAR);
		req.rd_en   = accept;
		req.wr_addr = cursor_q[IDX_W-1:0];
		req.rd_addr = cursor_nxt[IDX_W-1:0];
		req.wr_data = cmd_ch.data_byte;
	end

	tdb_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_char)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			mode_q   <= MODE_NONE;
			valid_s1 <= 1'b0;
			mode_s1  <= MODE_NONE;
		end else begin
			if (accept) begin
				cursor_q <= cursor_nxt;
				mode_q   <= mode_nxt;
				mode_s1  <= mode_nxt;
				valid_s1 <= 1'b1;
			end else if (bus_ch.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cursor_s1 <= cursor_nxt;
		end
	end

	assign bus_ch.valid      = valid_s1;
	assign bus_ch.bus_driven = (mode_s1 == MODE_ADDR) || (mode_s1 == MODE_CHAR);

	always_comb begin
		case (mode_s1)
			MODE_ADDR: bus_ch.bus_value = cursor_s1;
			MODE_CHAR: bus_ch.bus_value = rd_char;
			default:   bus_ch.bus_value = '0;
		endcase
	end

	ap_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q < CELLS_POS)
		else $error("cursor left the store range");

	ap_clear_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == CMD_CLEAR) |=>
			valid_s1 && (cursor_q == '0) && ((mode_s1 != MODE_CHAR) || (rd_char == '0)))
		else $error("clear did not zero cursor and cell");

	ap_write_readback: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == CMD_WRITE) |=> rd_char == $past(cmd_ch.data_byte))
		else $error("written character not seen at cursor");

	ap_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !bus_ch.ready |=> valid_s1 && $stable(cursor_s1) && $stable(rd_char))
		else $error("pending result changed while stalled");

endmodule

// ===== bench/text_display_buffer_unit_chk.sv =====
// Bus checker for the text display buffer unit: tracks the store, predicts each bus beat, compares.
module text_display_buffer_unit_chk (
	input  logic clk,
	input  logic arst_n,
	tdb_cmd_if   cmd_ch,
	tdb_bus_if   bus_ch,
	output int   errors,
	output int   pending,
	output int   checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import tdb_pkg::*;

	typedef struct packed {
		logic             driven;
		logic [CHR_W-1:0] value;
	} bus_beat_t;

	logic [CHR_W-1:0] shadow_cells [CELLS];
	logic [POS_W-1:0] shadow_pos;
	mode_t            shadow_mode;
	bus_beat_t        bus_expected [$];

	function automatic logic [POS_W-1:0] pos_forward(input logic [POS_W-1:0] pos);
		return (pos >= LAST_POS) ? '0 : pos + 1'b1;
	endfunction

	// Applies one command to the shadow state and returns what the bus should show after it.
	function automatic bus_beat_t bus_after(input logic [CMD_W-1:0] action,
			input logic [CHR_W-1:0] data_byte);
		bus_beat_t beat;
		case (action)
			CMD_STOP:       shadow_mode = MODE_NONE;
			CMD_SET_POS:    shadow_pos = (data_byte >= CELLS_POS) ? '0 : data_byte;
			CMD_WRITE:      shadow_cells[shadow_pos] = data_byte;
			CMD_WRITE_NEXT: begin
				shadow_cells[shadow_pos] = data_byte;
				shadow_pos = pos_forward(shadow_pos);
			end
			CMD_NEXT:       shadow_pos = pos_forward(shadow_pos);
			CMD_PREV:       shadow_pos = (shadow_pos == '0) ? LAST_POS : shadow_pos - 1'b1;
			CMD_OUT_ADDR:   shadow_mode = MODE_ADDR;
			CMD_OUT_CHAR:   shadow_mode = MODE_CHAR;
			CMD_HOME:       shadow_pos = '0;
			CMD_CLEAR: begin
				shadow_pos = '0;
				foreach (shadow_cells[i]) shadow_cells[i] = '0;
			end
			default: ;
		endcase
		case (shadow_mode)
			MODE_ADDR: beat = '{driven: 1'b1, value: shadow_pos};
			MODE_CHAR: beat = '{driven: 1'b1, value: shadow_cells[shadow_pos]};
			default:   beat = '{driven: 1'b0, value: '0};
		endcase
		return beat;
	endfunction

	task automatic flag(input string what, input bus_beat_t want, input bus_beat_t got);
		errors++;
		if (errors <= 10)
			$display("%0t ERROR %s: expected driven=%0b value=%02h, got driven=%0b value=%02h",
				$realtime, what, want.driven, want.value, got.driven, got.value);
	endtask

	always @(posedge clk or negedge arst_n) begin
		bus_beat_t want;
		bus_beat_t got;
		if (!arst_n) begin
			foreach (shadow_cells[i]) shadow_cells[i] = '0;
			shadow_pos  = '0;
			shadow_mode = MODE_NONE;
			bus_expected.delete();
			pending = 0;
		end else begin
			// Result beats first: a beat accepted now can only belong to an earlier command.
			if (bus_ch.valid && bus_ch.ready) begin
				got = '{driven: bus_ch.bus_driven, value: bus_ch.bus_value};
				if (bus_expected.size() == 0) begin
					flag("bus beat with no command outstanding", '0, got);
				end else begin
					want = bus_expected.pop_front();
					if (got !== want)
						flag("bus beat mismatch", want, got);
				end
				checked++;
			end
			if (cmd_ch.valid && cmd_ch.ready)
				bus_expected.push_back(bus_after(cmd_ch.action, cmd_ch.data_byte));
			pending = bus_expected.size();
		end
	end

endmodule

// ===== bench/text_display_buffer_unit_tb.sv =====
// Testbench top for the text display buffer unit: clock, reset, command stimulus and verdict.
module text_display_buffer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tdb_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd10;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   checked;
	int   gap_pct;
	int   stall_pct;
	int   n_cmds;
	int   n_unused;
	int   n_clears;

	tdb_cmd_if cmd_ch ();
	tdb_bus_if bus_ch ();

	text_display_buffer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_ch (cmd_ch),
		.bus_ch (bus_ch)
	);

	text_display_buffer_unit_chk chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_ch  (cmd_ch),
		.bus_ch  (bus_ch),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

	// Result side back-pressure in bursts.
	initial begin
		bus_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				bus_ch.ready = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			bus_ch.ready = 1'b1;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send(input logic [CMD_W-1:0] action, input logic [CHR_W-1:0] data_byte);
		if ($urandom_range(0, 99) < gap_pct) begin
			cmd_ch.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		cmd_ch.valid     = 1'b1;
		cmd_ch.action    = action;
		cmd_ch.data_byte = data_byte;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
		if (action > CMD_CLEAR)
			n_unused++;
		else
			n_cmds++;
		if (action == CMD_CLEAR)
			n_clears++;
	endtask

	// Weighted towards writes and cursor moves so the store fills up between clears.
	task automatic random_cmd();
		int               pick;
		logic [CHR_W-1:0] pos;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			send(CMD_WRITE_NEXT, CHR_W'($urandom));
		else if (pick < 35)
			send(CMD_WRITE, CHR_W'($urandom));
		else if (pick < 45)
			send(CMD_NEXT, CHR_W'($urandom));
		else if (pick < 55)
			send(CMD_PREV, CHR_W'($urandom));
		else if (pick < 63) begin
			case ($urandom_range(0, 3))
				0:       pos = CHR_W'($urandom);
				1: begin
					case ($urandom_range(0, 4))
						0:       pos = '0;
						1:       pos = LAST_POS - 1'b1;
						2:       pos = LAST_POS;
						3:       pos = CELLS_POS;
						default: pos = '1;
					endcase
				end
				default: pos = CHR_W'($urandom_range(0, CELLS - 1));
			endcase
			send(CMD_SET_POS, pos);
		end else if (pick < 71)
			send(CMD_OUT_CHAR, CHR_W'($urandom));
		else if (pick < 77)
			send(CMD_OUT_ADDR, CHR_W'($urandom));
		else if (pick < 80)
			send(CMD_STOP, CHR_W'($urandom));
		else if (pick < 83)
			send(CMD_HOME, CHR_W'($urandom));
		else if (pick < 85)
			send(CMD_CLEAR, CHR_W'($urandom));
		else
			send(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), CHR_W'($urandom));
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int wait_cycles;
		arst_n           = 1'b0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.action    = CMD_STOP;
		cmd_ch.data_byte = '0;
		gap_pct          = 0;
		stall_pct        = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: boundaries, wraps, unused codes, clear.
		send(CMD_OUT_CHAR, 8'h00);
		send(CMD_WRITE, 8'hFF);
		send(CMD_OUT_ADDR, 8'hFF);
		send(CMD_SET_POS, LAST_POS);
		send(CMD_WRITE_NEXT, 8'hA5);
		send(CMD_PREV, 8'h00);
		send(CMD_OUT_CHAR, 8'h00);
		send(CMD_NEXT, 8'hFF);
		send(CMD_SET_POS, CELLS_POS);
		send(CMD_SET_POS, 8'hFF);
		send(CMD_SET_POS, 8'h5A);
		send(CMD_WRITE, 8'h00);
		send(CMD_HOME, 8'h00);
		send(CMD_PREV, 8'h00);
		send(CMD_OUT_ADDR, 8'h00);
		send(CMD_UNUSED_LO, 8'hFF);
		send(CMD_UNUSED_HI, 8'h55);
		send(CMD_CLEAR, 8'hAA);
		send(CMD_OUT_CHAR, 8'h00);
		send(CMD_SET_POS, LAST_POS);
		send(CMD_STOP, 8'hFF);
		send(CMD_WRITE_NEXT, 8'h3C);
		send(CMD_OUT_CHAR, 8'h00);

		gap_pct   = 25;
		stall_pct = 25;
		while (n_cmds + n_unused < 650) random_cmd();

		// Hold off until the bus has caught up, then hit it with heavy back-pressure.
		cmd_ch.valid = 1'b0;
		drain();
		gap_pct   = 10;
		stall_pct = 50;
		while (n_cmds + n_unused < 1300) random_cmd();

		cmd_ch.valid = 1'b0;
		drain();
		gap_pct   = 0;
		stall_pct = 0;
		while (n_cmds + n_unused < 1950) random_cmd();
		cmd_ch.valid = 1'b0;

		for (wait_cycles = 0; pending != 0 && wait_cycles < 1000; wait_cycles++)
			@(negedge clk);
		repeat (4) @(negedge clk);

		$display("Sent %0d commands plus %0d with unused codes, %0d of them clears.",
			n_cmds, n_unused, n_clears);
		$display("Checked %0d bus beats, %0d still outstanding.", checked, pending);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
